FILE: src/i4bqd_pkg.sv
// Shared types and constants for the int4 blockwise quantized dot product.
// Holds the stream item layouts, register indexes and the controller/datapath links.
// No dependencies.
package i4bqd_pkg;

  // default upper bounds of the configurable sizes
  localparam int DEF_MAX_BLOCK_LENGTH = 256;
  localparam int DEF_MAX_BLOCKS       = 64;
  localparam int DEF_MAX_DIM          = 4096;

  localparam int ACT_W   = 16;
  localparam int CODE_W  = 4;
  localparam int SCALE_W = 16;
  localparam int ACC_W   = 50;
  localparam int IDX_W   = 12;

  localparam logic [CODE_W-1:0] DEFAULT_ZP = 4'd8;

  localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ZP_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS       = 3'd4;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [CODE_W-1:0]         zero_point;
    logic signed [SCALE_W-1:0] scale;
    logic [CODE_W-1:0]         weight_code;
    logic signed [ACT_W-1:0]   activation;
  } in_item_t;

  localparam int IN_W = $bits(in_item_t);

  // result item, padded to whole bytes
  typedef struct packed {
    logic [5:0]              pad;
    logic [IDX_W-1:0]        col_index;
    logic [IDX_W-1:0]        row_index;
    logic signed [ACC_W-1:0] dot_value;
  } out_item_t;

  localparam int OUT_W = $bits(out_item_t);

  typedef struct packed {
    logic accept;
    logic diff;
    logic mul;
    logic acc;
  } dp_cmd_t;

  typedef struct packed {
    logic block_end;
    logic row_done;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: src/i4bqd_ctrl.sv
// Sequencer for the quantized dot product: item accept and the block-end steps.
// Depends on i4bqd_pkg for the command and status structs.
module i4bqd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  i4bqd_pkg::dp_status_t  status,
  output i4bqd_pkg::dp_cmd_t     cmd
);
  import i4bqd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIFF = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_ACC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && status.block_end) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        // when this step completes a row, hold while a finished result still occupies the output register
        if (!(status.row_done && status.out_busy)) begin
          cmd.acc   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: src/i4bqd_datapath.sv
// Datapath: configuration registers, block sums, dequantization, row accumulator,
// position counters and the output register. Depends on i4bqd_pkg.
module i4bqd_datapath #(
  parameter int MAX_BLOCK_LENGTH = i4bqd_pkg::DEF_MAX_BLOCK_LENGTH,
  parameter int MAX_BLOCKS       = i4bqd_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_DIM          = i4bqd_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [i4bqd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i4bqd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [i4bqd_pkg::IN_W-1:0]        in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i4bqd_pkg::OUT_W-1:0]       out_tdata,
  input  i4bqd_pkg::dp_cmd_t                cmd,
  output i4bqd_pkg::dp_status_t             status
);
  import i4bqd_pkg::*;

  localparam int LW  = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int BW  = $clog2(MAX_BLOCKS + 1);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int LG  = $clog2(MAX_BLOCK_LENGTH);
  localparam int APW = ACT_W + CODE_W + 1;          // activation * code
  localparam int WSW = APW + LG;                     // weighted sum
  localparam int ASW = ACT_W + LG + 1;               // activation sum
  localparam int ZAW = ASW + CODE_W + 1;             // zp * activation sum
  localparam int DFW = ZAW + 1;                      // difference
  localparam int PW  = SCALE_W + DFW;                // scaled difference
  localparam int SW  = ((PW > ACC_W) ? PW : ACC_W) + 1;

  localparam logic signed [SW-1:0] SAT_HI = SW'(ACC_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(ACC_MIN);

  in_item_t item;
  assign item = in_item_t'(in_tdata);

  // configuration
  logic                  zp_present_r;
  logic [8:0]            blk_len_r;
  logic [6:0]            nblk_r;
  logic [12:0]           rows_r;
  logic [12:0]           cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_present_r <= 1'b0;
      blk_len_r    <= 9'd32;
      nblk_r       <= 7'd1;
      rows_r       <= 13'd1;
      cols_r       <= 13'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ZP_PRESENT: zp_present_r <= cfg_data[0];
        CFG_BLOCK_LEN:  blk_len_r    <= cfg_data[8:0];
        CFG_BLOCKS:     nblk_r       <= cfg_data[6:0];
        CFG_ROWS:       rows_r       <= cfg_data;
        CFG_COLS:       cols_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, above the maximum acts as the maximum
  logic [LW-1:0] len_eff;
  logic [BW-1:0] nblk_eff;
  logic [DW-1:0] rows_eff, cols_eff;

  always_comb begin
    if (blk_len_r == '0)                     len_eff = LW'(1);
    else if (32'(blk_len_r) > MAX_BLOCK_LENGTH) len_eff = LW'(MAX_BLOCK_LENGTH);
    else                                     len_eff = LW'(blk_len_r);
    if (nblk_r == '0)                        nblk_eff = BW'(1);
    else if (32'(nblk_r) > MAX_BLOCKS)       nblk_eff = BW'(MAX_BLOCKS);
    else                                     nblk_eff = BW'(nblk_r);
    if (rows_r == '0)                        rows_eff = DW'(1);
    else if (32'(rows_r) > MAX_DIM)          rows_eff = DW'(MAX_DIM);
    else                                     rows_eff = DW'(rows_r);
    if (cols_r == '0)                        cols_eff = DW'(1);
    else if (32'(cols_r) > MAX_DIM)          cols_eff = DW'(MAX_DIM);
    else                                     cols_eff = DW'(cols_r);
  end

  // counters
  logic [LW-1:0] elem_r;
  logic [BW-1:0] blk_r;
  logic [DW-1:0] row_r, col_r;
  logic [LW:0]   elem_inc;
  logic [BW:0]   blk_inc;
  logic [DW:0]   row_inc, col_inc;

  assign elem_inc = {1'b0, elem_r} + 1'b1;
  assign blk_inc  = {1'b0, blk_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_inc  = {1'b0, col_r} + 1'b1;

  assign status.block_end = (elem_inc >= {1'b0, len_eff});
  assign status.row_done  = (blk_inc >= {1'b0, nblk_eff});
  assign status.out_busy  = out_tvalid && !out_tready;

  // arithmetic
  logic signed [WSW-1:0]    wsum_r;
  logic signed [ASW-1:0]    asum_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic [CODE_W-1:0]        zp_r;
  logic signed [DFW-1:0]    diff_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [APW-1:0]    act_code;
  logic signed [ZAW-1:0]    zp_asum;
  logic signed [PW-1:0]     scaled;
  logic signed [SW-1:0]     acc_sum, acc_sat;

  assign act_code = item.activation * $signed({1'b0, item.weight_code});
  assign zp_asum  = asum_r * $signed({1'b0, zp_r});
  assign scaled   = scale_r * diff_r;
  assign acc_sum  = SW'(acc_r) + SW'(prod_r);

  always_comb begin
    if (acc_sum > SAT_HI)      acc_sat = SAT_HI;
    else if (acc_sum < SAT_LO) acc_sat = SAT_LO;
    else                       acc_sat = acc_sum;
  end

  out_item_t out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r      <= '0;
      asum_r      <= '0;
      acc_r       <= '0;
      elem_r      <= '0;
      blk_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one taken in this same cycle
      if (cmd.acc && status.row_done) out_valid_r <= 1'b1;
      else if (out_tready)            out_valid_r <= 1'b0;
      if (cmd.accept) begin
        wsum_r  <= wsum_r + WSW'(act_code);
        asum_r  <= asum_r + ASW'(item.activation);
        scale_r <= item.scale;
        zp_r    <= zp_present_r ? item.zero_point : DEFAULT_ZP;
        elem_r  <= status.block_end ? '0 : elem_inc[LW-1:0];
      end
      if (cmd.diff) begin
        diff_r <= DFW'(wsum_r) - DFW'(zp_asum);
        wsum_r <= '0;
        asum_r <= '0;
      end
      if (cmd.mul) prod_r <= scaled;
      if (cmd.acc) begin
        if (status.row_done) begin
          out_r.pad       <= '0;
          out_r.dot_value <= acc_sat[ACC_W-1:0];
          out_r.row_index <= IDX_W'(row_r);
          out_r.col_index <= IDX_W'(col_r);
          acc_r           <= '0;
          blk_r           <= '0;
          if (row_inc >= {1'b0, rows_eff}) begin
            row_r <= '0;
            col_r <= (col_inc >= {1'b0, cols_eff}) ? '0 : col_inc[DW-1:0];
          end else begin
            row_r <= row_inc[DW-1:0];
          end
        end else begin
          acc_r <= acc_sat[ACC_W-1:0];
          blk_r <= blk_inc[BW-1:0];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

FILE: src/int4_blockwise_quantized_dot_product.sv
// Top level of the int4 blockwise quantized dot product.
// Depends on i4bqd_pkg, i4bqd_ctrl and i4bqd_datapath.
//
// Each input item carries one Q7.8 activation and one 4-bit weight code; the
// last item of a quantization block also supplies the block scale (Q3.12) and
// zero point. An item that does not end a block is taken in the idle state. The
// item that ends a block is accepted and then runs the three-step sequence of the
// controller: the zero-point correction, the scale multiply and the saturating add
// into the row accumulator; no new item is taken meanwhile. When a row of blocks
// completes and the output register still holds an untaken result, the accumulate
// step waits until it is taken. Results (Q.20 value, row, column) come column-major.
// Configuration writes are taken in every cycle; write only while idle.
module int4_blockwise_quantized_dot_product #(
  parameter int MAX_BLOCK_LENGTH = i4bqd_pkg::DEF_MAX_BLOCK_LENGTH,
  parameter int MAX_BLOCKS       = i4bqd_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_DIM          = i4bqd_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i4bqd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i4bqd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // activation, weight_code, scale, zero_point
  input  logic [i4bqd_pkg::IN_W-1:0]        in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // dot_value, row_index, col_index, zero pad
  output logic [i4bqd_pkg::OUT_W-1:0]       out_tdata
);
  import i4bqd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  i4bqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  i4bqd_datapath #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH),
    .MAX_BLOCKS       (MAX_BLOCKS),
    .MAX_DIM          (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

FILE: src/i4bqd_checker.sv
// Port-level checks for the int4 blockwise quantized dot product, bound to its top.
// Depends on i4bqd_pkg and int4_blockwise_quantized_dot_product.
module i4bqd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i4bqd_pkg::OUT_W-1:0]       out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // input ready only drops after an item was taken
  a_ready_keep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready dropped without an item");

  // a new result appears only at the end of a block-end sequence
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared outside the accumulate step");

endmodule

bind int4_blockwise_quantized_dot_product i4bqd_checker u_i4bqd_checker (.*);

FILE: verif/tb_int4_blockwise_quantized_dot_product.sv
// Self-checking testbench for int4_blockwise_quantized_dot_product.
// Streams activation/weight items, predicts each dequantized dot product
// in-line and checks every result item; depends on i4bqd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_int4_blockwise_quantized_dot_product;
  import i4bqd_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic signed [ACC_W-1:0] dot_value;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
  } dot_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;

  // predicted copy of the block's registers and state
  logic              zp_given = 1'b0;
  logic [8:0]        blk_len = 9'd32;
  logic [6:0]        blk_per_row = 7'd1;
  logic [12:0]       m_rows = 13'd1;
  logic [12:0]       n_cols = 13'd1;
  longint            wsum = 0;
  longint            asum = 0;
  logic signed [ACC_W-1:0] row_acc = '0;
  int unsigned       elem_cnt = 0;
  int unsigned       blk_cnt = 0;
  int unsigned       row_cnt = 0;
  int unsigned       col_cnt = 0;

  dot_result_t pending_dots[$];

  int unsigned send_gap_max = 13;
  int unsigned sink_stall_max = 13;
  int unsigned sink_wait = 0;
  int unsigned results_taken = 0;
  int unsigned taken_seen = 0;
  int unsigned items_sent = 0;
  int unsigned dots_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  int4_blockwise_quantized_dot_product u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Fold one item into the block and row sums; queue a result when a row completes.
  function automatic void accumulate_item(input in_item_t it);
    longint act, zp, diff, sum;
    dot_result_t res;
    act = longint'($signed(it.activation));
    wsum += act * longint'(it.weight_code);
    asum += act;
    elem_cnt++;
    if (elem_cnt < clamp_count(blk_len, DEF_MAX_BLOCK_LENGTH)) return;

    zp = zp_given ? longint'(it.zero_point) : longint'(DEFAULT_ZP);
    diff = wsum - zp * asum;
    sum = longint'(row_acc) + longint'($signed(it.scale)) * diff;
    if (sum > ACC_MAX) sum = ACC_MAX;
    else if (sum < ACC_MIN) sum = ACC_MIN;
    row_acc = sum[ACC_W-1:0];
    wsum = 0;
    asum = 0;
    elem_cnt = 0;
    blk_cnt++;
    if (blk_cnt < clamp_count(blk_per_row, DEF_MAX_BLOCKS)) return;

    res.dot_value = row_acc;
    res.row_index = row_cnt[IDX_W-1:0];
    res.col_index = col_cnt[IDX_W-1:0];
    pending_dots.push_back(res);
    row_acc = '0;
    blk_cnt = 0;
    row_cnt++;
    if (row_cnt >= clamp_count(m_rows, DEF_MAX_DIM)) begin
      row_cnt = 0;
      col_cnt++;
      if (col_cnt >= clamp_count(n_cols, DEF_MAX_DIM)) col_cnt = 0;
    end
  endfunction

  function automatic in_item_t make_item(input int act, input int code, input int scl,
                                         input int zp);
    in_item_t it;
    it.activation  = act[ACT_W-1:0];
    it.weight_code = code[CODE_W-1:0];
    it.scale       = scl[SCALE_W-1:0];
    it.zero_point  = zp[CODE_W-1:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it = IN_W'({$urandom, $urandom});
    // lean on the ends of the signed ranges now and then
    if ($urandom_range(0, 7) == 0) it.activation = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if ($urandom_range(0, 7) == 0) it.scale = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return it;
  endfunction

  function automatic int unsigned pick_idle_max();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 13;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    errors++;
  endtask

  // Enter and leave at a falling edge; tvalid stays high for the caller's next item.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= it;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every predicted result has drained, then let the block finish.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_dots.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZP_PRESENT: zp_given    = value[0];
      CFG_BLOCK_LEN:  blk_len     = value[8:0];
      CFG_BLOCKS:     blk_per_row = value[6:0];
      CFG_ROWS:       m_rows      = value[12:0];
      CFG_COLS:       n_cols      = value[12:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic configure(input logic zp, input logic [CFG_DATA_W-1:0] len,
                           input logic [CFG_DATA_W-1:0] nblk, input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols);
    settle_block();
    write_reg(CFG_ZP_PRESENT, CFG_DATA_W'(zp));
    write_reg(CFG_BLOCK_LEN, len);
    write_reg(CFG_BLOCKS, nblk);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  // Random content under the settings the block comes out of reset with.
  task automatic test_reset_config();
    send_gap_max = 13;
    sink_stall_max = 13;
    repeat (64) send_item(random_item());
  endtask

  // One item per result on a 2x2 grid, so rows and columns wrap.
  task automatic test_field_extremes();
    configure(1'b1, 1, 1, 2, 2);
    send_item(make_item(32767, 15, 32767, 0));
    send_item(make_item(-32768, 15, -32768, 0));
    send_item(make_item(-32768, 0, 32767, 15));
    send_item(make_item(32767, 0, -32768, 15));
    send_item(make_item(-1, 15, -1, 15));
    send_item(make_item(0, 0, 0, 0));
  endtask

  // Zero point field must be ignored when none is given.
  task automatic test_fixed_zero_point();
    configure(1'b0, 2, 2, 1, 1);
    send_item(make_item(1000, 15, 4096, 15));
    send_item(make_item(-700, 0, 4096, 0));
    send_item(make_item(-32768, 8, -32768, 15));
    send_item(make_item(32767, 3, -4096, 1));
  endtask

  // Zero sizes act as one.
  task automatic test_size_floor();
    configure(1'b1, 0, 0, 0, 0);
    send_item(make_item(256, 9, 4096, 3));
    send_item(make_item(-256, 2, -4096, 12));
    send_item(make_item(12345, 14, 777, 7));
  endtask

  // Lower each limit while a block, a row or a column is part way through.
  task automatic test_midstream_change();
    send_gap_max = 13;
    sink_stall_max = 13;
    configure(1'b1, 4, 1, 3, 1);
    repeat (3) send_item(random_item());
    configure(1'b1, 2, 1, 3, 1);
    send_item(random_item());
    configure(1'b1, 1, 3, 3, 2);
    repeat (2) send_item(random_item());
    configure(1'b1, 1, 1, 3, 2);
    send_item(random_item());
    configure(1'b1, 1, 1, 1, 2);
    repeat (2) send_item(random_item());
  endtask

  // Longest block with the largest magnitudes, then sizes above the maxima.
  task automatic test_largest_sizes();
    send_gap_max = 0;
    sink_stall_max = 0;
    configure(1'b1, 256, 1, 1, 1);
    repeat (256) send_item(make_item(-32768, 15, -32768, 0));
    configure(1'b0, 13'h01FF, 1, 1, 1);
    repeat (256) send_item(random_item());
    configure(1'b1, 1, 13'h007F, 2, 1);
    repeat (128) send_item(random_item());
  endtask

  // Phases of random settings; mostly whole rows, some partial rows left hanging.
  task automatic test_random_traffic();
    logic                  zp;
    logic [CFG_DATA_W-1:0] len, nblk, rows, cols;
    int unsigned           span, count;
    while (items_sent < 1630) begin
      zp = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = CFG_DATA_W'($urandom_range(7, 20));
        default: len = CFG_DATA_W'($urandom_range(1, 5));
      endcase
      if ($urandom_range(0, 9) == 0) len[12:9] = 4'($urandom);
      case ($urandom_range(0, 9))
        0: nblk = 0;
        1: nblk = CFG_DATA_W'($urandom_range(4, 8));
        default: nblk = CFG_DATA_W'($urandom_range(1, 3));
      endcase
      if ($urandom_range(0, 9) == 0) nblk[12:7] = 6'($urandom);
      case ($urandom_range(0, 9))
        0: rows = 0;
        1: rows = 13'h1FFF;
        2: rows = 4096;
        default: rows = CFG_DATA_W'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 9))
        0: cols = 0;
        1: cols = CFG_DATA_W'($urandom_range(1, 16));
        default: cols = CFG_DATA_W'($urandom_range(1, 4));
      endcase
      configure(zp, len, nblk, rows, cols);
      send_gap_max = pick_idle_max();
      sink_stall_max = pick_idle_max();
      span = clamp_count(len[8:0], DEF_MAX_BLOCK_LENGTH) * clamp_count(nblk[6:0], DEF_MAX_BLOCKS);
      count = span * $urandom_range(1, (span > 40) ? 2 : 8);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, span);
      repeat (count) send_item(random_item());
    end
  endtask

  // Result sink: draw a stall after each result, drive ready at the falling edge.
  always @(negedge clk) begin
    if (taken_seen != results_taken) begin
      taken_seen = results_taken;
      sink_wait = $urandom_range(0, sink_stall_max);
    end
    if (sink_wait != 0) begin
      out_tready <= 1'b0;
      sink_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t   got;
    dot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_taken++;
      if (pending_dots.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d row %0d col %0d",
                                  got.dot_value, got.row_index, got.col_index));
      end else begin
        want = pending_dots.pop_front();
        dots_checked++;
        if (got.dot_value !== want.dot_value)
          report_mismatch($sformatf("dot_value %0d, predicted %0d (row %0d col %0d)",
                                    got.dot_value, want.dot_value, want.row_index,
                                    want.col_index));
        if (got.row_index !== want.row_index)
          report_mismatch($sformatf("row_index %0d, predicted %0d",
                                    got.row_index, want.row_index));
        if (got.col_index !== want.col_index)
          report_mismatch($sformatf("col_index %0d, predicted %0d",
                                    got.col_index, want.col_index));
      end
    end
  end

  // Watchdog: end the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_dots.size());
      $display("int4_blockwise_quantized_dot_product: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_field_extremes();
    test_fixed_zero_point();
    test_size_floor();
    test_midstream_change();
    test_largest_sizes();
    test_random_traffic();
    settle_block();
    repeat (END_CYCLES) @(negedge clk);
    if (pending_dots.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", pending_dots.size()));
    $display("Run covered %0d input items, %0d checked results, %0d register writes.",
             items_sent, dots_checked, cfg_writes);
    $display("Settings ranged from zero sizes to above-maximum block and row sizes.");
    if (errors == 0) begin
      $display("int4_blockwise_quantized_dot_product: match");
    end else begin
      $display("int4_blockwise_quantized_dot_product: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
src/i4bqd_pkg.sv
src/i4bqd_ctrl.sv
src/i4bqd_datapath.sv
src/int4_blockwise_quantized_dot_product.sv
src/i4bqd_checker.sv
verif/tb_int4_blockwise_quantized_dot_product.sv
